[src/ldf_pkg.sv]
package ldf_pkg;

  // Configuration register indexes (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_COEF_CONSTANT   = 3'd0,
    REG_COEF_HOURLY     = 3'd1,
    REG_COEF_DAY_LENGTH = 3'd2,
    REG_COEF_ELEVATION  = 3'd3,
    REG_COEF_DAILY      = 3'd4
  } reg_idx_t;

  localparam logic signed [31:0] COEF_CONSTANT_RST   = -32'sd157286;
  localparam logic signed [31:0] COEF_HOURLY_RST     = 32'sd181535;
  localparam logic signed [31:0] COEF_DAY_LENGTH_RST = 32'sd2163;
  localparam logic signed [31:0] COEF_ELEVATION_RST  = 32'sd3539;
  localparam logic signed [31:0] COEF_DAILY_RST      = 32'sd67371;

  localparam logic signed [15:0] NIGHT_SIN_MAX = 16'sd163;
  localparam logic signed [15:0] SIN_ONE       = 16'sd16384;
  localparam logic [16:0]        Q16_ONE       = 17'd65536;
  localparam logic [30:0]        Q30_ONE       = 31'h4000_0000;
  localparam logic [46:0]        Q46_ONE       = 47'h4000_0000_0000;

  // Arcsine polynomial, Q16.
  localparam logic signed [31:0] ASIN_P3 = -32'sd1227;
  localparam logic signed [31:0] ASIN_P2 = 32'sd4867;
  localparam logic signed [31:0] ASIN_P1 = -32'sd13901;
  localparam logic signed [31:0] ASIN_P0 = 32'sd102939;
  localparam logic signed [39:0] HALF_PI_Q16 = 40'sd102944;

  localparam logic [21:0] BETA_CAP      = 22'h20_0000;
  localparam logic [16:0] LOG2E_Q16     = 17'd94548;
  localparam logic [29:0] LN2_Q30       = 30'd744261118;
  localparam logic [5:0]  EXP_SHIFT_MAX = 6'd31;

  // Q16 product of a signed value and a non-negative value, rounded half
  // away from zero.
  function automatic logic signed [39:0] mul_q16(input logic signed [31:0] a,
                                                 input logic [21:0] b);
    logic [31:0] mag;
    logic [53:0] prod;
    logic [39:0] rnd;
    mag = a[31] ? (~a + 32'd1) : a;
    prod = 54'(mag) * 54'(b);
    rnd = 40'((prod + 54'd32768) >> 16);
    mul_q16 = a[31] ? -$signed(rnd) : $signed(rnd);
  endfunction

endpackage

[src/ldf_div_pipe.sv]
module ldf_div_pipe #(
  parameter int DEN_W = 16,
  parameter int Q_W   = 16,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_in,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [Q_W-1:0]   low_in,
  input  logic [DEN_W-1:0] den_in,
  input  logic [TAG_W-1:0] tag_in,
  output logic             vld_out,
  output logic [Q_W-1:0]   quo_out,
  output logic [TAG_W-1:0] tag_out
);

  // One quotient bit per stage, restoring division. The partial remainder
  // entering must already be below the divisor.
  logic             vld_r [0:Q_W];
  logic [DEN_W-1:0] rem_r [0:Q_W];
  logic [Q_W-1:0]   low_r [0:Q_W];
  logic [DEN_W-1:0] den_r [0:Q_W];
  logic [Q_W-1:0]   quo_r [0:Q_W];
  logic [TAG_W-1:0] tag_r [0:Q_W];

  assign vld_r[0] = vld_in;
  assign rem_r[0] = rem_in;
  assign low_r[0] = low_in;
  assign den_r[0] = den_in;
  assign quo_r[0] = '0;
  assign tag_r[0] = tag_in;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           fits;
    assign trial = {rem_r[i], low_r[i][Q_W-1]};
    assign fits  = trial >= {1'b0, den_r[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      rem_r[i+1] <= fits ? DEN_W'(trial - {1'b0, den_r[i]}) : trial[DEN_W-1:0];
      low_r[i+1] <= low_r[i] << 1;
      den_r[i+1] <= den_r[i];
      quo_r[i+1] <= {quo_r[i][Q_W-2:0], fits};
      tag_r[i+1] <= tag_r[i];
    end
  end

  assign vld_out = vld_r[Q_W];
  assign quo_out = quo_r[Q_W];
  assign tag_out = tag_r[Q_W];

endmodule

[src/ldf_sqrt_pipe.sv]
module ldf_sqrt_pipe #(
  parameter int RAD_W = 34,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_in,
  input  logic [RAD_W-1:0]   rad_in,
  input  logic [TAG_W-1:0]   tag_in,
  output logic               vld_out,
  output logic [RAD_W/2-1:0] root_out,
  output logic [TAG_W-1:0]   tag_out
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  // Digit-by-digit floor square root, one root bit per stage.
  logic              vld_r  [0:ROOT_W];
  logic [RAD_W-1:0]  rad_r  [0:ROOT_W];
  logic [ROOT_W-1:0] root_r [0:ROOT_W];
  logic [REM_W-1:0]  rem_r  [0:ROOT_W];
  logic [TAG_W-1:0]  tag_r  [0:ROOT_W];

  assign vld_r[0]  = vld_in;
  assign rad_r[0]  = rad_in;
  assign root_r[0] = '0;
  assign rem_r[0]  = '0;
  assign tag_r[0]  = tag_in;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    logic             fits;
    assign shifted = {rem_r[i], rad_r[i][RAD_W-1 -: 2]};
    assign trial   = (REM_W+2)'({root_r[i], 2'b01});
    assign fits    = shifted >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      rem_r[i+1]  <= fits ? REM_W'(shifted - trial) : REM_W'(shifted);
      root_r[i+1] <= {root_r[i][ROOT_W-2:0], fits};
      rad_r[i+1]  <= rad_r[i] << 2;
      tag_r[i+1]  <= tag_r[i];
    end
  end

  assign vld_out  = vld_r[ROOT_W];
  assign root_out = root_r[ROOT_W];
  assign tag_out  = tag_r[ROOT_W];

endmodule

[src/ldf_taylor_step.sv]
module ldf_taylor_step import ldf_pkg::*; #(
  parameter int K     = 1,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_in,
  input  logic [30:0]      r_in,
  input  logic [29:0]      g_in,
  input  logic [TAG_W-1:0] tag_in,
  output logic             vld_out,
  output logic [30:0]      r_out,
  output logic [29:0]      g_out,
  output logic [TAG_W-1:0] tag_out
);

  // r_out = 1 - floor(floor(g*r) / K), all Q30. The division by K is a
  // reciprocal multiply that can fall short by one, then one correction.
  localparam logic [31:0] RECIP = 32'((64'd1 << 31) / 64'(K));
  localparam logic [3:0]  K_V   = 4'(K);

  logic             vld_a_r, vld_b_r, vld_c_r;
  logic [29:0]      pr_a_r, pr_b_r, q0_b_r;
  logic [29:0]      g_a_r, g_b_r, g_c_r;
  logic [TAG_W-1:0] tag_a_r, tag_b_r, tag_c_r;
  logic [30:0]      r_c_r;

  logic [60:0] prod_a;
  logic [61:0] prod_b;
  logic [33:0] chk;
  logic [29:0] q_nxt;

  assign prod_a = 61'(g_in) * 61'(r_in);
  assign prod_b = 62'(pr_a_r) * 62'(RECIP);
  assign chk    = 34'(pr_b_r) - 34'(q0_b_r) * 34'(K_V);
  assign q_nxt  = (chk >= 34'(K_V)) ? q0_b_r + 30'd1 : q0_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      vld_a_r <= vld_in;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
    pr_a_r  <= prod_a[59:30];
    g_a_r   <= g_in;
    tag_a_r <= tag_in;
    pr_b_r  <= pr_a_r;
    q0_b_r  <= prod_b[60:31];
    g_b_r   <= g_a_r;
    tag_b_r <= tag_a_r;
    r_c_r   <= Q30_ONE - 31'(q_nxt);
    g_c_r   <= g_b_r;
    tag_c_r <= tag_b_r;
  end

  assign vld_out = vld_c_r;
  assign r_out   = r_c_r;
  assign g_out   = g_c_r;
  assign tag_out = tag_c_r;

endmodule

[src/logistic_diffuse_fraction_unit.sv]
// Logistic diffuse fraction unit. One weather record is taken at each rising
// edge where start is high; busy is tied low because the datapath is a fully
// pipelined chain that accepts a record in every cycle, and the sender may
// start on every cycle without limit. Each record gives exactly one result
// beat on out_strobe, in order; the receiver must take every beat in the
// cycle it is shown, as nothing here can hold a result back. The chain of
// units holds a 17-stage square-root pipe (the clearness dividers run
// alongside it), three Horner stages of the arcsine, the stages for the
// coefficient products, the sum and the exponent scaling, eight exp Taylor
// steps of three stages each, and a 17-stage divider for 1/(1+exp(beta)).
// The five coefficients sit on the APB port at byte addresses 0, 4, 8, 12
// and 16 and should only be written while no record is in flight.
module logistic_diffuse_fraction_unit import ldf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_sin_elevation,
  input  logic [15:0]        in_hour_global_rad,
  input  logic [15:0]        in_hour_extra_rad,
  input  logic [14:0]        in_day_hours,
  input  logic [15:0]        in_day_global_rad,
  input  logic [15:0]        in_day_extra_rad,
  output logic               out_strobe,
  output logic [16:0]        out_diffuse_fraction,
  output logic               out_night_flag,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Edges from taking a record to sampling its result beat.
  localparam int PIPE_LAT = 71;

  // ---------------------------------------------------------------------
  // Coefficient registers. A write lands in the access phase; addresses
  // past the last register are ignored and read back as zero.
  // ---------------------------------------------------------------------
  logic signed [31:0] c_const_r, c_hourly_r, c_day_r, c_elev_r, c_daily_r;
  reg_idx_t           reg_idx;
  logic               cfg_wr;

  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_const_r  <= COEF_CONSTANT_RST;
      c_hourly_r <= COEF_HOURLY_RST;
      c_day_r    <= COEF_DAY_LENGTH_RST;
      c_elev_r   <= COEF_ELEVATION_RST;
      c_daily_r  <= COEF_DAILY_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COEF_CONSTANT:   c_const_r  <= pwdata;
        REG_COEF_HOURLY:     c_hourly_r <= pwdata;
        REG_COEF_DAY_LENGTH: c_day_r    <= pwdata;
        REG_COEF_ELEVATION:  c_elev_r   <= pwdata;
        REG_COEF_DAILY:      c_daily_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COEF_CONSTANT:   prdata = c_const_r;
      REG_COEF_HOURLY:     prdata = c_hourly_r;
      REG_COEF_DAY_LENGTH: prdata = c_day_r;
      REG_COEF_ELEVATION:  prdata = c_elev_r;
      REG_COEF_DAILY:      prdata = c_daily_r;
      default:             prdata = '0;
    endcase
  end

  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Input stage. The night test is exact: 100*sin < 16384 holds for a
  // sine of 163 or less. A sine above one is clamped so the angle is pi/2.
  // A clearness ratio is one when the divisor is zero or when global
  // radiation reaches the extraterrestrial value; otherwise the divider
  // sees a numerator below its divisor.
  // ---------------------------------------------------------------------
  logic               s0_vld_r, s0_night_r;
  logic [16:0]        s0_x_r;
  logic [20:0]        s0_hours_r;
  logic [15:0]        s0_kt_rem_r, s0_kt_den_r, s0_dkt_rem_r, s0_dkt_den_r;
  logic               s0_kt_one_r, s0_dkt_one_r;
  logic signed [15:0] sin_cl;

  assign sin_cl = (in_sin_elevation > SIN_ONE) ? SIN_ONE : in_sin_elevation;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start & ~busy;
    end
    s0_night_r   <= in_sin_elevation <= NIGHT_SIN_MAX;
    s0_x_r       <= {sin_cl[14:0], 2'b00};
    s0_hours_r   <= {in_day_hours, 6'b000000};
    s0_kt_one_r  <= (in_hour_extra_rad == 16'd0) || (in_hour_global_rad >= in_hour_extra_rad);
    s0_kt_rem_r  <= in_hour_global_rad;
    s0_kt_den_r  <= in_hour_extra_rad;
    s0_dkt_one_r <= (in_day_extra_rad == 16'd0) || (in_day_global_rad >= in_day_extra_rad);
    s0_dkt_rem_r <= in_day_global_rad;
    s0_dkt_den_r <= in_day_extra_rad;
  end

  // ---------------------------------------------------------------------
  // Clearness dividers and the square root of (1 - x), side by side.
  // ---------------------------------------------------------------------
  logic        kt_vld, dkt_vld, sq_vld;
  logic [15:0] kt_quo, dkt_quo;
  logic [0:0]  kt_one_d, dkt_one_d;
  logic [16:0] sq_root;
  logic [38:0] sq_tag;
  logic [33:0] sq_rad;

  assign sq_rad = {1'b0, 17'(Q16_ONE - s0_x_r), 16'h0000};

  ldf_div_pipe #(.DEN_W(16), .Q_W(16), .TAG_W(1)) u_kt_div (
    .clk, .rst_n,
    .vld_in (s0_vld_r),
    .rem_in (s0_kt_rem_r),
    .low_in (16'h0000),
    .den_in (s0_kt_den_r),
    .tag_in (s0_kt_one_r),
    .vld_out(kt_vld),
    .quo_out(kt_quo),
    .tag_out(kt_one_d)
  );

  ldf_div_pipe #(.DEN_W(16), .Q_W(16), .TAG_W(1)) u_dkt_div (
    .clk, .rst_n,
    .vld_in (s0_vld_r),
    .rem_in (s0_dkt_rem_r),
    .low_in (16'h0000),
    .den_in (s0_dkt_den_r),
    .tag_in (s0_dkt_one_r),
    .vld_out(dkt_vld),
    .quo_out(dkt_quo),
    .tag_out(dkt_one_d)
  );

  ldf_sqrt_pipe #(.RAD_W(34), .TAG_W(39)) u_sqrt (
    .clk, .rst_n,
    .vld_in  (s0_vld_r),
    .rad_in  (sq_rad),
    .tag_in  ({s0_night_r, s0_hours_r, s0_x_r}),
    .vld_out (sq_vld),
    .root_out(sq_root),
    .tag_out (sq_tag)
  );

  // The dividers are one stage shorter than the root; this stage lines
  // them up and substitutes one for the special ratios.
  logic        kt_al_vld_r, dkt_al_vld_r;
  logic [16:0] kt_al_r, dkt_al_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kt_al_vld_r  <= 1'b0;
      dkt_al_vld_r <= 1'b0;
    end else begin
      kt_al_vld_r  <= kt_vld;
      dkt_al_vld_r <= dkt_vld;
    end
    kt_al_r  <= kt_one_d[0]  ? Q16_ONE : {1'b0, kt_quo};
    dkt_al_r <= dkt_one_d[0] ? Q16_ONE : {1'b0, dkt_quo};
  end

  // ---------------------------------------------------------------------
  // Arcsine: Horner polynomial in x over three stages, then
  // pi/2 - sqrt(1-x)*p(x), floored at zero.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic        vld;
    logic        night;
    logic [20:0] hours;
    logic [16:0] x;
    logic [16:0] kt;
    logic [16:0] dkt;
    logic [16:0] root;
  } asin_ctx_t;

  asin_ctx_t          f_ctx, h1_ctx_r, h2_ctx_r, h3_ctx_r;
  logic signed [31:0] h1_p_r, h2_p_r, h3_p_r;

  assign f_ctx = '{vld: sq_vld, night: sq_tag[38], hours: sq_tag[37:17], x: sq_tag[16:0],
                   kt: kt_al_r, dkt: dkt_al_r, root: sq_root};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_ctx_r.vld <= 1'b0;
      h2_ctx_r.vld <= 1'b0;
      h3_ctx_r.vld <= 1'b0;
    end else begin
      h1_ctx_r.vld <= f_ctx.vld;
      h2_ctx_r.vld <= h1_ctx_r.vld;
      h3_ctx_r.vld <= h2_ctx_r.vld;
    end
    {h1_ctx_r.night, h1_ctx_r.hours, h1_ctx_r.x, h1_ctx_r.kt, h1_ctx_r.dkt, h1_ctx_r.root} <=
      {f_ctx.night, f_ctx.hours, f_ctx.x, f_ctx.kt, f_ctx.dkt, f_ctx.root};
    {h2_ctx_r.night, h2_ctx_r.hours, h2_ctx_r.x, h2_ctx_r.kt, h2_ctx_r.dkt, h2_ctx_r.root} <=
      {h1_ctx_r.night, h1_ctx_r.hours, h1_ctx_r.x, h1_ctx_r.kt, h1_ctx_r.dkt, h1_ctx_r.root};
    {h3_ctx_r.night, h3_ctx_r.hours, h3_ctx_r.x, h3_ctx_r.kt, h3_ctx_r.dkt, h3_ctx_r.root} <=
      {h2_ctx_r.night, h2_ctx_r.hours, h2_ctx_r.x, h2_ctx_r.kt, h2_ctx_r.dkt, h2_ctx_r.root};
    h1_p_r <= 32'(40'(ASIN_P2) + mul_q16(ASIN_P3, {5'b00000, f_ctx.x}));
    h2_p_r <= 32'(40'(ASIN_P1) + mul_q16(h1_p_r, {5'b00000, h1_ctx_r.x}));
    h3_p_r <= 32'(40'(ASIN_P0) + mul_q16(h2_p_r, {5'b00000, h2_ctx_r.x}));
  end

  logic               a1_vld_r, a1_night_r;
  logic [20:0]        a1_hours_r;
  logic [16:0]        a1_kt_r, a1_dkt_r, a1_ang_r;
  logic signed [39:0] ang_diff;

  assign ang_diff = HALF_PI_Q16 - mul_q16(h3_p_r, {5'b00000, h3_ctx_r.root});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_vld_r <= 1'b0;
    end else begin
      a1_vld_r <= h3_ctx_r.vld;
    end
    a1_night_r <= h3_ctx_r.night;
    a1_hours_r <= h3_ctx_r.hours;
    a1_kt_r    <= h3_ctx_r.kt;
    a1_dkt_r   <= h3_ctx_r.dkt;
    a1_ang_r   <= ang_diff[39] ? 17'd0 : ang_diff[16:0];
  end

  // ---------------------------------------------------------------------
  // beta = c0 + c1*kt + c2*hours + c3*angle + c4*dkt: products in one
  // stage, then a two-level sum. No saturation; 42 bits hold any beta.
  // ---------------------------------------------------------------------
  logic               b1_vld_r, b1_night_r, b2_vld_r, b2_night_r, b3_vld_r, b3_night_r;
  logic signed [39:0] b1_mkt_r, b1_mhr_r, b1_mang_r, b1_mdkt_r;
  logic signed [41:0] b2_sa_r, b2_sb_r, b3_beta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
      b2_vld_r <= 1'b0;
      b3_vld_r <= 1'b0;
    end else begin
      b1_vld_r <= a1_vld_r;
      b2_vld_r <= b1_vld_r;
      b3_vld_r <= b2_vld_r;
    end
    b1_night_r <= a1_night_r;
    b1_mkt_r   <= mul_q16(c_hourly_r, {5'b00000, a1_kt_r});
    b1_mhr_r   <= mul_q16(c_day_r, {1'b0, a1_hours_r});
    b1_mang_r  <= mul_q16(c_elev_r, {5'b00000, a1_ang_r});
    b1_mdkt_r  <= mul_q16(c_daily_r, {5'b00000, a1_dkt_r});
    b2_night_r <= b1_night_r;
    b2_sa_r    <= 42'(c_const_r) + 42'(b1_mkt_r) + 42'(b1_mhr_r);
    b2_sb_r    <= 42'(b1_mang_r) + 42'(b1_mdkt_r);
    b3_night_r <= b2_night_r;
    b3_beta_r  <= b2_sa_r + b2_sb_r;
  end

  // ---------------------------------------------------------------------
  // exp(-|beta|): |beta| is capped at 32, scaled by log2(e) into an integer
  // shift n and a fraction f, and f*ln2 goes into the Taylor steps.
  // ---------------------------------------------------------------------
  logic        c1_vld_r, c1_night_r, c1_neg_r;
  logic [21:0] c1_t_r;
  logic        c2_vld_r, c2_night_r, c2_neg_r;
  logic [5:0]  c2_n_r;
  logic [15:0] c2_f_r;
  logic        c3_vld_r, c3_night_r, c3_neg_r;
  logic [5:0]  c3_n_r;
  logic [29:0] c3_g_r;
  logic [41:0] beta_mag;
  logic [38:0] u_full;
  logic [45:0] g_full;

  assign beta_mag = b3_beta_r[41] ? 42'(-b3_beta_r) : 42'(b3_beta_r);
  assign u_full   = 39'(c1_t_r) * 39'(LOG2E_Q16) + 39'd32768;
  assign g_full   = 46'(c2_f_r) * 46'(LN2_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
      c3_vld_r <= 1'b0;
    end else begin
      c1_vld_r <= b3_vld_r;
      c2_vld_r <= c1_vld_r;
      c3_vld_r <= c2_vld_r;
    end
    c1_night_r <= b3_night_r;
    c1_neg_r   <= b3_beta_r[41];
    c1_t_r     <= (beta_mag > 42'(BETA_CAP)) ? BETA_CAP : beta_mag[21:0];
    c2_night_r <= c1_night_r;
    c2_neg_r   <= c1_neg_r;
    c2_n_r     <= u_full[37:32];
    c2_f_r     <= u_full[31:16];
    c3_night_r <= c2_night_r;
    c3_neg_r   <= c2_neg_r;
    c3_n_r     <= c2_n_r;
    c3_g_r     <= g_full[45:16];
  end

  // Eight Taylor steps, divisor 8 down to 1. Side data: {night, neg, n}.
  logic        tv [0:8];
  logic [30:0] tr [0:8];
  logic [29:0] tg [0:8];
  logic [7:0]  tt [0:8];

  assign tv[0] = c3_vld_r;
  assign tr[0] = Q30_ONE;
  assign tg[0] = c3_g_r;
  assign tt[0] = {c3_night_r, c3_neg_r, c3_n_r};

  for (genvar j = 0; j < 8; j++) begin : g_taylor
    ldf_taylor_step #(.K(8 - j), .TAG_W(8)) u_step (
      .clk, .rst_n,
      .vld_in (tv[j]),
      .r_in   (tr[j]),
      .g_in   (tg[j]),
      .tag_in (tt[j]),
      .vld_out(tv[j+1]),
      .r_out  (tr[j+1]),
      .g_out  (tg[j+1]),
      .tag_out(tt[j+1])
    );
  end

  // ---------------------------------------------------------------------
  // Final fraction: E*2^16/(2^30+E) for beta >= 0, 2^46/(2^30+E) for a
  // negative beta, rounded half up. The quotient never exceeds 17 bits.
  // ---------------------------------------------------------------------
  logic        d1_vld_r;
  logic [0:0]  d1_night_r;
  logic [31:0] d1_rem_r, d1_den_r;
  logic [16:0] d1_low_r;
  logic [30:0] exp_e;
  logic [31:0] frac_den;
  logic [46:0] frac_num;

  assign exp_e    = (tt[8][5:0] >= EXP_SHIFT_MAX) ? 31'd0 : (tr[8] >> tt[8][5:0]);
  assign frac_den = 32'(Q30_ONE) + 32'(exp_e);
  assign frac_num = (tt[8][6] ? Q46_ONE : {exp_e, 16'h0000}) + 47'(frac_den >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
    end else begin
      d1_vld_r <= tv[8];
    end
    d1_night_r <= tt[8][7];
    d1_rem_r   <= 32'(frac_num[46:17]);
    d1_low_r   <= frac_num[16:0];
    d1_den_r   <= frac_den;
  end

  logic        fd_vld;
  logic [16:0] fd_quo;
  logic [0:0]  fd_night;

  ldf_div_pipe #(.DEN_W(32), .Q_W(17), .TAG_W(1)) u_frac_div (
    .clk, .rst_n,
    .vld_in (d1_vld_r),
    .rem_in (d1_rem_r),
    .low_in (d1_low_r),
    .den_in (d1_den_r),
    .tag_in (d1_night_r),
    .vld_out(fd_vld),
    .quo_out(fd_quo),
    .tag_out(fd_night)
  );

  // Output register. A night record reports a fraction of exactly one.
  logic        out_strobe_r, out_night_r;
  logic [16:0] out_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= fd_vld;
    end
    out_night_r <= fd_night[0];
    out_frac_r  <= (fd_night[0] || (fd_quo > Q16_ONE)) ? Q16_ONE : fd_quo;
  end

  assign out_strobe           = out_strobe_r;
  assign out_night_flag       = out_night_r;
  assign out_diffuse_fraction = out_frac_r;

`ifndef NO_ASSERTIONS
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_strobe)
    else $error("record taken without a result beat at the pipeline latency");

  a_no_stray : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LAT))
    else $error("result beat without a record taken at the pipeline latency");

  a_night : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_sin_elevation <= NIGHT_SIN_MAX)) |-> ##PIPE_LAT
      (out_night_flag && (out_diffuse_fraction == Q16_ONE)))
    else $error("night record did not yield a fraction of one");

  a_align : assert property (@(posedge clk) disable iff (!rst_n)
    (kt_al_vld_r == sq_vld) && (dkt_al_vld_r == sq_vld))
    else $error("clearness dividers out of step with the root pipe");
`endif

endmodule
